@@ rtl/core/uss_pkg.sv @@
// ----------------------------------------------------------------------------
// uss_pkg
// Types, codes and reset values shared by the shutdown sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package uss_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	localparam logic [6:0]  CHARGE_MAX      = 7'd100;
	localparam logic [15:0] RUNTIME_UNKNOWN = 16'hFFFF;

	localparam logic        RST_ARMED          = 1'b0;
	localparam logic        RST_USE_LOW_BATT   = 1'b1;
	localparam logic [6:0]  RST_CRIT_CHARGE    = 7'd20;
	localparam logic [15:0] RST_CRIT_RUNTIME   = 16'd120;
	localparam logic [31:0] RST_GRACE          = 32'd300;
	localparam logic [31:0] RST_MAINS_STABLE   = 32'd60;
	localparam logic [31:0] RST_MIN_OFF        = 32'd30;

	typedef enum logic [3:0] {
		ST_STARTING    = 4'd0,
		ST_MONITOR     = 4'd1,
		ST_DEGRADED    = 4'd2,
		ST_MAINS       = 4'd3,
		ST_GRACE       = 4'd4,
		ST_SHUTDOWN    = 4'd5,
		ST_WAIT_OFF    = 4'd6,
		ST_CUTTING     = 4'd7,
		ST_WAIT_MAINS  = 4'd8,
		ST_STABILISING = 4'd9,
		ST_RESTORING   = 4'd10,
		ST_RECOVERY    = 4'd11,
		ST_ERROR       = 4'd12
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_SHUTDOWN   = 2'd1,
		ACT_OUTLET_OFF = 2'd2,
		ACT_OUTLET_ON  = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		RSN_DISARMED         = 5'd0,
		RSN_UNREACHABLE      = 5'd1,
		RSN_AMBIGUOUS        = 5'd2,
		RSN_START_BATTERY    = 5'd3,
		RSN_START_MAINS      = 5'd4,
		RSN_BATTERY_CONFIRM  = 5'd5,
		RSN_MAINS_STABLE     = 5'd6,
		RSN_MAINS_IN_GRACE   = 5'd7,
		RSN_CRITICAL         = 5'd8,
		RSN_GRACE_EXPIRED    = 5'd9,
		RSN_GRACE_WAIT       = 5'd10,
		RSN_SHUTDOWN_SENT    = 5'd11,
		RSN_SHUTDOWN_REPEAT  = 5'd12,
		RSN_HOST_OFF         = 5'd13,
		RSN_HOST_OFF_WAIT    = 5'd14,
		RSN_OUTLET_OFF       = 5'd15,
		RSN_OUTLET_OFF_WAIT  = 5'd16,
		RSN_MAINS_RESTORED   = 5'd17,
		RSN_MAINS_WAIT       = 5'd18,
		RSN_MAINS_LOST       = 5'd19,
		RSN_SHORT_OUTAGE     = 5'd20,
		RSN_RESTORE          = 5'd21,
		RSN_STABILITY_CHECK  = 5'd22,
		RSN_OUTLET_ON        = 5'd23,
		RSN_OUTLET_ON_WAIT   = 5'd24,
		RSN_HOST_BOOTED      = 5'd25,
		RSN_HOST_BOOT_WAIT   = 5'd26,
		RSN_ERROR_MANUAL     = 5'd27,
		RSN_UNKNOWN_STATE    = 5'd28
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ARMED        = 3'd0,
		CFG_USE_LOW_BATT = 3'd1,
		CFG_CRIT_CHARGE  = 3'd2,
		CFG_CRIT_RUNTIME = 3'd3,
		CFG_GRACE        = 3'd4,
		CFG_MAINS_STABLE = 3'd5,
		CFG_MIN_OFF      = 3'd6
	} cfg_idx_t;

	localparam logic [1:0] OUTLET_OFF = 2'd1;
	localparam logic [1:0] OUTLET_ON  = 2'd2;

	typedef struct packed {
		logic                 armed;
		logic                 low_flag_critical;
		logic [6:0]           critical_charge;
		logic [15:0]          critical_runtime;
		logic [31:0]          grace_limit;
		logic [31:0]          mains_settle;
		logic [31:0]          outlet_rest;
	} cfg_t;

	typedef struct packed {
		logic [3:0]           current_state;
		logic [TIME_BITS-1:0] now_seconds;
		logic [TIME_BITS-1:0] battery_since;
		logic [TIME_BITS-1:0] mains_since;
		logic [TIME_BITS-1:0] outlet_off_since;
		logic [1:0]           record_flags;
		logic [3:0]           ups_flags;
		logic [6:0]           charge_percent;
		logic [15:0]          runtime_seconds;
		logic [1:0]           host_flags;
		logic [1:0]           outlet_state;
	} request_t;

	typedef struct packed {
		state_t               next_state;
		action_t              action;
		reason_t              reason_code;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/uss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// uss_cfg_regs
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_cfg_regs
	import uss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.armed             <= RST_ARMED;
			cfg_q.low_flag_critical <= RST_USE_LOW_BATT;
			cfg_q.critical_charge   <= RST_CRIT_CHARGE;
			cfg_q.critical_runtime  <= RST_CRIT_RUNTIME;
			cfg_q.grace_limit       <= RST_GRACE;
			cfg_q.mains_settle      <= RST_MAINS_STABLE;
			cfg_q.outlet_rest       <= RST_MIN_OFF;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ARMED:        cfg_q.armed             <= wr_data[0];
				CFG_USE_LOW_BATT: cfg_q.low_flag_critical <= wr_data[0];
				CFG_CRIT_CHARGE:  cfg_q.critical_charge   <= wr_data[6:0];
				CFG_CRIT_RUNTIME: cfg_q.critical_runtime  <= wr_data[15:0];
				CFG_GRACE:        cfg_q.grace_limit       <= wr_data[31:0];
				CFG_MAINS_STABLE: cfg_q.mains_settle      <= wr_data[31:0];
				CFG_MIN_OFF:      cfg_q.outlet_rest       <= wr_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/uss_decide.sv @@
// ----------------------------------------------------------------------------
// uss_decide
// Decision logic: global checks, then the per-state transition rules.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_decide
	import uss_pkg::*;
(
	input  wire cfg_t     cfg,
	input  wire request_t request,
	output result_t       result
);

	function automatic logic elapsed(
		input logic [TIME_BITS-1:0] now,
		input logic [TIME_BITS-1:0] since,
		input logic [CFG_W-1:0]     thr
	);
		logic [TIME_BITS-1:0] diff;
		logic [CMP_W-1:0]     diff_x;
		logic [CMP_W-1:0]     thr_x;
		diff   = now - since;
		diff_x = CMP_W'(diff);
		thr_x  = CMP_W'(thr);
		return (since != '0) && (now >= since) && (diff_x >= thr_x);
	endfunction

	logic reach, online, onbat, low_batt;
	logic sent, was_cut, host_off, host_up;
	logic critical;
	logic grace_done, mains_done, off_done;

	assign reach    = request.ups_flags[0];
	assign online   = request.ups_flags[1];
	assign onbat    = request.ups_flags[2];
	assign low_batt = request.ups_flags[3];
	assign sent     = request.record_flags[0];
	assign was_cut  = request.record_flags[1];
	assign host_off = request.host_flags[0];
	assign host_up  = request.host_flags[1];

	assign critical = (cfg.low_flag_critical && low_batt)
		|| ((request.charge_percent <= CHARGE_MAX)
			&& (request.charge_percent <= cfg.critical_charge))
		|| ((request.runtime_seconds != RUNTIME_UNKNOWN)
			&& (request.runtime_seconds <= cfg.critical_runtime));

	assign grace_done = elapsed(request.now_seconds, request.battery_since,
		cfg.grace_limit);
	assign mains_done = elapsed(request.now_seconds, request.mains_since,
		cfg.mains_settle);
	assign off_done   = elapsed(request.now_seconds, request.outlet_off_since,
		cfg.outlet_rest);

	always_comb begin
		result.next_state  = ST_ERROR;
		result.action      = ACT_NONE;
		result.reason_code = RSN_UNKNOWN_STATE;
		priority if (!cfg.armed) begin
			result.next_state  = ST_MONITOR;
			result.reason_code = RSN_DISARMED;
		end else if (!reach) begin
			result.next_state  = ST_DEGRADED;
			result.reason_code = RSN_UNREACHABLE;
		end else if (!online && !onbat) begin
			result.next_state  = ST_DEGRADED;
			result.reason_code = RSN_AMBIGUOUS;
		end else begin
			unique case (request.current_state)
				ST_STARTING, ST_MONITOR, ST_DEGRADED: begin
					if (onbat) begin
						result.next_state  = ST_GRACE;
						result.reason_code = RSN_START_BATTERY;
					end else begin
						result.next_state  = ST_MAINS;
						result.reason_code = RSN_START_MAINS;
					end
				end
				ST_MAINS: begin
					if (onbat) begin
						result.next_state  = ST_GRACE;
						result.reason_code = RSN_BATTERY_CONFIRM;
					end else begin
						result.next_state  = ST_MAINS;
						result.reason_code = RSN_MAINS_STABLE;
					end
				end
				ST_GRACE: begin
					priority if (online) begin
						result.next_state  = ST_STABILISING;
						result.reason_code = RSN_MAINS_IN_GRACE;
					end else if (critical) begin
						result.next_state  = ST_SHUTDOWN;
						result.action      = ACT_SHUTDOWN;
						result.reason_code = RSN_CRITICAL;
					end else if (grace_done) begin
						result.next_state  = ST_SHUTDOWN;
						result.action      = ACT_SHUTDOWN;
						result.reason_code = RSN_GRACE_EXPIRED;
					end else begin
						result.next_state  = ST_GRACE;
						result.reason_code = RSN_GRACE_WAIT;
					end
				end
				ST_SHUTDOWN: begin
					if (sent) begin
						result.next_state  = ST_WAIT_OFF;
						result.reason_code = RSN_SHUTDOWN_SENT;
					end else begin
						result.next_state  = ST_SHUTDOWN;
						result.action      = ACT_SHUTDOWN;
						result.reason_code = RSN_SHUTDOWN_REPEAT;
					end
				end
				ST_WAIT_OFF: begin
					if (host_off) begin
						result.next_state  = ST_CUTTING;
						result.action      = ACT_OUTLET_OFF;
						result.reason_code = RSN_HOST_OFF;
					end else begin
						result.next_state  = ST_WAIT_OFF;
						result.reason_code = RSN_HOST_OFF_WAIT;
					end
				end
				ST_CUTTING: begin
					if (request.outlet_state == OUTLET_OFF) begin
						result.next_state  = ST_WAIT_MAINS;
						result.reason_code = RSN_OUTLET_OFF;
					end else begin
						result.next_state  = ST_CUTTING;
						result.action      = ACT_OUTLET_OFF;
						result.reason_code = RSN_OUTLET_OFF_WAIT;
					end
				end
				ST_WAIT_MAINS: begin
					if (online) begin
						result.next_state  = ST_STABILISING;
						result.reason_code = RSN_MAINS_RESTORED;
					end else begin
						result.next_state  = ST_WAIT_MAINS;
						result.reason_code = RSN_MAINS_WAIT;
					end
				end
				ST_STABILISING: begin
					result.next_state  = ST_STABILISING;
					result.reason_code = RSN_STABILITY_CHECK;
					priority if (onbat) begin
						result.next_state  = ST_WAIT_MAINS;
						result.reason_code = RSN_MAINS_LOST;
					end else if (mains_done && !was_cut) begin
						result.next_state  = ST_MAINS;
						result.reason_code = RSN_SHORT_OUTAGE;
					end else if (mains_done && off_done) begin
						result.next_state  = ST_RESTORING;
						result.action      = ACT_OUTLET_ON;
						result.reason_code = RSN_RESTORE;
					end else begin
					end
				end
				ST_RESTORING: begin
					if (request.outlet_state == OUTLET_ON) begin
						result.next_state  = ST_RECOVERY;
						result.reason_code = RSN_OUTLET_ON;
					end else begin
						result.next_state  = ST_RESTORING;
						result.action      = ACT_OUTLET_ON;
						result.reason_code = RSN_OUTLET_ON_WAIT;
					end
				end
				ST_RECOVERY: begin
					if (host_up) begin
						result.next_state  = ST_MAINS;
						result.reason_code = RSN_HOST_BOOTED;
					end else begin
						result.next_state  = ST_RECOVERY;
						result.reason_code = RSN_HOST_BOOT_WAIT;
					end
				end
				ST_ERROR: begin
					result.next_state  = ST_ERROR;
					result.reason_code = RSN_ERROR_MANUAL;
				end
				default: begin
					result.next_state  = ST_ERROR;
					result.reason_code = RSN_UNKNOWN_STATE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ups_shutdown_sequencer.sv @@
// ----------------------------------------------------------------------------
// ups_shutdown_sequencer
// Power-sequencing decision block for UPS events.
// ----------------------------------------------------------------------------
// A request beat is taken at every clock edge with start high; busy is always
// low, so a new beat can follow every cycle. Each request is captured in the
// input register, the decision logic works on it, and its result is captured
// in the result register, shown for one cycle with done high.
// The receiver cannot stall, so results must be taken as they come.
// Configuration writes take effect at the next edge and should only be
// made while no request is in flight.
`default_nettype none

module ups_shutdown_sequencer
	import uss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire request_t             request,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	cfg_t     cfg;
	request_t request_s1;
	logic     valid_s1;
	result_t  decision;
	result_t  result_s2;
	logic     valid_s2;

	assign busy = 1'b0;

	uss_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			request_s1 <= request;
		end
		if (valid_s1) begin
			result_s2 <= decision;
		end
	end

	uss_decide u_decide (
		.cfg     (cfg),
		.request (request_s1),
		.result  (decision)
	);

	assign done   = valid_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

@@ rtl/core/uss_checker.sv @@
// ----------------------------------------------------------------------------
// uss_checker
// Port-level checks on the shutdown sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_checker
	import uss_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	a_beat_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a request beat");

	a_codes_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.next_state <= ST_ERROR
			&& result.reason_code <= RSN_UNKNOWN_STATE))
		else $error("result code out of range");

	a_shutdown_state: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.action == ACT_SHUTDOWN) |-> result.next_state == ST_SHUTDOWN)
		else $error("shutdown request outside shutdown state");

endmodule

bind ups_shutdown_sequencer uss_checker u_uss_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

@@ tb/sv/uss_decision_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uss_decision_checker
// Watches the request, result and register ports of the shutdown sequencer.
// Keeps its own copy of the settings, predicts each decision as a request
// beat is taken, and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module uss_decision_checker
	import uss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  request_t             request,
	input  logic                 done,
	input  result_t              result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output int                   errors,
	output int                   pending
);

	localparam int UPS_REACH_BIT  = 0;
	localparam int UPS_ONLINE_BIT = 1;
	localparam int UPS_BATT_BIT   = 2;
	localparam int UPS_LOW_BIT    = 3;
	localparam int REC_SENT_BIT   = 0;
	localparam int REC_CUT_BIT    = 1;
	localparam int HOST_OFF_BIT   = 0;
	localparam int HOST_UP_BIT    = 1;
	localparam int PRINT_LIMIT    = 100;

	cfg_t    settings;
	result_t expected_decisions[$];
	result_t want;

	function automatic result_t make_decision(input state_t s, input action_t a,
			input reason_t r);
		result_t d;
		d.next_state  = s;
		d.action      = a;
		d.reason_code = r;
		return d;
	endfunction

	// set timestamp, not in the future, and at least span seconds old
	function automatic logic held_for(input logic [TIME_BITS-1:0] now,
			input logic [TIME_BITS-1:0] since, input logic [31:0] span);
		logic [63:0] gone;
		gone = 64'(now) - 64'(since);
		return (since != '0) && (now >= since) && (gone >= 64'(span));
	endfunction

	function automatic logic battery_low(input cfg_t c, input request_t q);
		return (c.low_flag_critical && q.ups_flags[UPS_LOW_BIT]) ||
			(q.charge_percent <= CHARGE_MAX && q.charge_percent <= c.critical_charge) ||
			(q.runtime_seconds != RUNTIME_UNKNOWN &&
			 q.runtime_seconds <= c.critical_runtime);
	endfunction

	function automatic result_t decide_next(input cfg_t c, input request_t q);
		logic    reach;
		logic    online;
		logic    onbat;
		result_t d;
		reach  = q.ups_flags[UPS_REACH_BIT];
		online = q.ups_flags[UPS_ONLINE_BIT];
		onbat  = q.ups_flags[UPS_BATT_BIT];
		if (!c.armed) begin
			d = make_decision(ST_MONITOR, ACT_NONE, RSN_DISARMED);
		end else if (!reach) begin
			d = make_decision(ST_DEGRADED, ACT_NONE, RSN_UNREACHABLE);
		end else if (!online && !onbat) begin
			d = make_decision(ST_DEGRADED, ACT_NONE, RSN_AMBIGUOUS);
		end else begin
			case (q.current_state)
			ST_STARTING, ST_MONITOR, ST_DEGRADED: begin
				d = onbat ? make_decision(ST_GRACE, ACT_NONE, RSN_START_BATTERY)
					: make_decision(ST_MAINS, ACT_NONE, RSN_START_MAINS);
			end
			ST_MAINS: begin
				d = onbat ? make_decision(ST_GRACE, ACT_NONE, RSN_BATTERY_CONFIRM)
					: make_decision(ST_MAINS, ACT_NONE, RSN_MAINS_STABLE);
			end
			ST_GRACE: begin
				if (online)
					d = make_decision(ST_STABILISING, ACT_NONE, RSN_MAINS_IN_GRACE);
				else if (battery_low(c, q))
					d = make_decision(ST_SHUTDOWN, ACT_SHUTDOWN, RSN_CRITICAL);
				else if (held_for(q.now_seconds, q.battery_since, c.grace_limit))
					d = make_decision(ST_SHUTDOWN, ACT_SHUTDOWN, RSN_GRACE_EXPIRED);
				else
					d = make_decision(ST_GRACE, ACT_NONE, RSN_GRACE_WAIT);
			end
			ST_SHUTDOWN: begin
				d = q.record_flags[REC_SENT_BIT]
					? make_decision(ST_WAIT_OFF, ACT_NONE, RSN_SHUTDOWN_SENT)
					: make_decision(ST_SHUTDOWN, ACT_SHUTDOWN, RSN_SHUTDOWN_REPEAT);
			end
			ST_WAIT_OFF: begin
				d = q.host_flags[HOST_OFF_BIT]
					? make_decision(ST_CUTTING, ACT_OUTLET_OFF, RSN_HOST_OFF)
					: make_decision(ST_WAIT_OFF, ACT_NONE, RSN_HOST_OFF_WAIT);
			end
			ST_CUTTING: begin
				d = (q.outlet_state == OUTLET_OFF)
					? make_decision(ST_WAIT_MAINS, ACT_NONE, RSN_OUTLET_OFF)
					: make_decision(ST_CUTTING, ACT_OUTLET_OFF, RSN_OUTLET_OFF_WAIT);
			end
			ST_WAIT_MAINS: begin
				d = online ? make_decision(ST_STABILISING, ACT_NONE, RSN_MAINS_RESTORED)
					: make_decision(ST_WAIT_MAINS, ACT_NONE, RSN_MAINS_WAIT);
			end
			ST_STABILISING: begin
				d = make_decision(ST_STABILISING, ACT_NONE, RSN_STABILITY_CHECK);
				if (onbat) begin
					d = make_decision(ST_WAIT_MAINS, ACT_NONE, RSN_MAINS_LOST);
				end else if (held_for(q.now_seconds, q.mains_since,
						c.mains_settle)) begin
					if (!q.record_flags[REC_CUT_BIT])
						d = make_decision(ST_MAINS, ACT_NONE, RSN_SHORT_OUTAGE);
					else if (held_for(q.now_seconds, q.outlet_off_since,
							c.outlet_rest))
						d = make_decision(ST_RESTORING, ACT_OUTLET_ON, RSN_RESTORE);
				end
			end
			ST_RESTORING: begin
				d = (q.outlet_state == OUTLET_ON)
					? make_decision(ST_RECOVERY, ACT_NONE, RSN_OUTLET_ON)
					: make_decision(ST_RESTORING, ACT_OUTLET_ON, RSN_OUTLET_ON_WAIT);
			end
			ST_RECOVERY: begin
				d = q.host_flags[HOST_UP_BIT]
					? make_decision(ST_MAINS, ACT_NONE, RSN_HOST_BOOTED)
					: make_decision(ST_RECOVERY, ACT_NONE, RSN_HOST_BOOT_WAIT);
			end
			ST_ERROR: begin
				d = make_decision(ST_ERROR, ACT_NONE, RSN_ERROR_MANUAL);
			end
			default: begin
				d = make_decision(ST_ERROR, ACT_NONE, RSN_UNKNOWN_STATE);
			end
			endcase
		end
		return d;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_LIMIT)
			$display("%0t ERROR %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.armed             = RST_ARMED;
			settings.low_flag_critical = RST_USE_LOW_BATT;
			settings.critical_charge   = RST_CRIT_CHARGE;
			settings.critical_runtime  = RST_CRIT_RUNTIME;
			settings.grace_limit       = RST_GRACE;
			settings.mains_settle      = RST_MAINS_STABLE;
			settings.outlet_rest       = RST_MIN_OFF;
			expected_decisions.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_decisions.size() == 0) begin
					report_mismatch("result beat with no request outstanding");
				end else begin
					want = expected_decisions.pop_front();
					if (result.next_state !== want.next_state)
						report_mismatch($sformatf("next_state expected %0d got %0d",
							want.next_state, result.next_state));
					if (result.action !== want.action)
						report_mismatch($sformatf("action expected %0d got %0d",
							want.action, result.action));
					if (result.reason_code !== want.reason_code)
						report_mismatch($sformatf("reason_code expected %0d got %0d",
							want.reason_code, result.reason_code));
				end
			end
			if (start && !busy)
				expected_decisions.push_back(decide_next(settings, request));
			if (wr_en) begin
				case (wr_index)
				CFG_ARMED:        settings.armed             = wr_data[0];
				CFG_USE_LOW_BATT: settings.low_flag_critical = wr_data[0];
				CFG_CRIT_CHARGE:  settings.critical_charge   = wr_data[6:0];
				CFG_CRIT_RUNTIME: settings.critical_runtime  = wr_data[15:0];
				CFG_GRACE:        settings.grace_limit       = wr_data;
				CFG_MAINS_STABLE: settings.mains_settle      = wr_data;
				CFG_MIN_OFF:      settings.outlet_rest       = wr_data;
				default: ;
				endcase
			end
			pending = expected_decisions.size();
		end
	end

endmodule

@@ tb/sv/ups_shutdown_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ups_shutdown_sequencer_tb
// Drives request beats and register writes into the shutdown sequencer: a
// directed pass over every decision rule, then random observation records
// under several register settings and sender idle rates. Prediction and
// comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module ups_shutdown_sequencer_tb;
	import uss_pkg::*;

	localparam logic [3:0] UPS_REACH   = 4'b0001;
	localparam logic [3:0] UPS_ONLINE  = 4'b0010;
	localparam logic [3:0] UPS_ON_BATT = 4'b0100;
	localparam logic [3:0] UPS_LOW     = 4'b1000;
	localparam logic [3:0] ON_MAINS    = UPS_REACH | UPS_ONLINE;
	localparam logic [3:0] ON_BATT     = UPS_REACH | UPS_ON_BATT;
	localparam logic [1:0] REC_SENT    = 2'b01;
	localparam logic [1:0] REC_CUT     = 2'b10;
	localparam logic [1:0] HOST_OFF    = 2'b01;
	localparam logic [1:0] HOST_UP     = 2'b10;
	localparam logic [1:0] OUTLET_UNKNOWN = 2'd0;
	localparam logic [1:0] OUTLET_BAD     = 2'd3;
	localparam logic [3:0] ST_SPARE_LO    = 4'd13;
	localparam logic [3:0] ST_SPARE_HI    = 4'd15;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	request_t             request_item;
	logic                 done;
	result_t              result_beat;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	int                   errors;
	int                   pending;

	int          sender_idle;
	logic [6:0]  crit_charge_now;
	logic [15:0] crit_runtime_now;
	logic [31:0] grace_now;
	logic [31:0] stable_now;
	logic [31:0] min_off_now;
	request_t    probe;

	ups_shutdown_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request_item),
		.done     (done),
		.result   (result_beat),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	uss_decision_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request_item),
		.done     (done),
		.result   (result_beat),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic issue(input request_t r);
		int gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle)
			gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		request_item <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic program_regs(input logic arm, input logic low_flag, input logic [6:0] chg,
			input logic [15:0] rt, input logic [31:0] grace, input logic [31:0] stable,
			input logic [31:0] min_off);
		write_reg(CFG_ARMED, 32'(arm));
		write_reg(CFG_USE_LOW_BATT, 32'(low_flag));
		write_reg(CFG_CRIT_CHARGE, 32'(chg));
		write_reg(CFG_CRIT_RUNTIME, 32'(rt));
		write_reg(CFG_GRACE, grace);
		write_reg(CFG_MAINS_STABLE, stable);
		write_reg(CFG_MIN_OFF, min_off);
		crit_charge_now  = chg;
		crit_runtime_now = rt;
		grace_now        = grace;
		stable_now       = stable;
		min_off_now      = min_off;
	endtask

	// stop sending and let every outstanding beat come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic request_t calm_request(input logic [3:0] st);
		request_t r;
		r                 = '0;
		r.current_state   = st;
		r.now_seconds     = 32'd100000;
		r.ups_flags       = ON_MAINS;
		r.charge_percent  = 7'd80;
		r.runtime_seconds = 16'd1000;
		return r;
	endfunction

	// timestamps clustered around the threshold edge, plus unset and future ones
	function automatic logic [31:0] pick_since(input logic [31:0] now, input logic [31:0] span);
		case ($urandom_range(6))
		0:       return '0;
		1:       return now - span;
		2:       return now - span + 32'd1;
		3:       return now - span - 32'd1;
		4:       return now + 32'($urandom_range(1, 1000));
		5:       return now;
		default: return $urandom;
		endcase
	endfunction

	function automatic request_t random_request();
		request_t    r;
		logic [3:0]  u;
		logic [31:0] now;
		case ($urandom_range(9))
		0:       now = '0;
		1:       now = '1;
		default: now = $urandom;
		endcase
		if ($urandom_range(4) != 0) begin
			case ($urandom_range(2))
			0:       u = ON_MAINS;
			1:       u = ON_BATT;
			default: u = ON_MAINS | UPS_ON_BATT;
			endcase
			if ($urandom_range(1))
				u = u | UPS_LOW;
		end else begin
			u = 4'($urandom_range(15));
		end
		if ($urandom_range(15) == 0)
			r.current_state = 4'($urandom_range(ST_SPARE_LO, ST_SPARE_HI));
		else
			r.current_state = 4'($urandom_range(ST_ERROR));
		r.now_seconds      = now;
		r.battery_since    = pick_since(now, grace_now);
		r.mains_since      = pick_since(now, stable_now);
		r.outlet_off_since = pick_since(now, min_off_now);
		r.record_flags     = 2'($urandom_range(3));
		r.ups_flags        = u;
		case ($urandom_range(5))
		0:       r.charge_percent = 7'($urandom_range(127));
		1:       r.charge_percent = crit_charge_now + 7'($urandom_range(2)) - 7'd1;
		2:       r.charge_percent = CHARGE_MAX;
		3:       r.charge_percent = CHARGE_MAX + 7'd1;
		4:       r.charge_percent = 7'($urandom_range(101, 127));
		default: r.charge_percent = 7'($urandom_range(100));
		endcase
		case ($urandom_range(4))
		0:       r.runtime_seconds = 16'($urandom_range(65535));
		1:       r.runtime_seconds = crit_runtime_now + 16'($urandom_range(2)) - 16'd1;
		2:       r.runtime_seconds = RUNTIME_UNKNOWN;
		3:       r.runtime_seconds = RUNTIME_UNKNOWN - 16'd1;
		default: r.runtime_seconds = 16'($urandom_range(300));
		endcase
		r.host_flags   = 2'($urandom_range(3));
		r.outlet_state = 2'($urandom_range(3));
		return r;
	endfunction

	initial begin
		arst_n       <= 1'b0;
		start        <= 1'b0;
		request_item <= '0;
		wr_en        <= 1'b0;
		wr_index     <= '0;
		wr_data      <= '0;
		sender_idle  = 0;
		crit_charge_now  = RST_CRIT_CHARGE;
		crit_runtime_now = RST_CRIT_RUNTIME;
		grace_now        = RST_GRACE;
		stable_now       = RST_MAINS_STABLE;
		min_off_now      = RST_MIN_OFF;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// disarmed after reset, fields at both extremes
		issue('0);
		issue('1);
		drain();
		program_regs(1'b1, RST_USE_LOW_BATT, RST_CRIT_CHARGE, RST_CRIT_RUNTIME,
			RST_GRACE, RST_MAINS_STABLE, RST_MIN_OFF);
		write_reg(CFG_SPARE, '1);

		// at least one beat per decision rule
		probe = calm_request(ST_GRACE);    probe.ups_flags = '0;        issue(probe);
		probe = calm_request(ST_GRACE);    probe.ups_flags = UPS_REACH; issue(probe);
		probe = calm_request(ST_STARTING); probe.ups_flags = ON_BATT;   issue(probe);
		probe = calm_request(ST_DEGRADED);                              issue(probe);
		probe = calm_request(ST_MAINS);    probe.ups_flags = ON_BATT;   issue(probe);
		probe = calm_request(ST_MAINS);                                 issue(probe);
		probe = calm_request(ST_GRACE);                                 issue(probe);
		probe = calm_request(ST_GRACE); probe.ups_flags = ON_BATT | UPS_LOW; issue(probe);
		probe = calm_request(ST_GRACE); probe.ups_flags = ON_BATT;
		probe.charge_percent = RST_CRIT_CHARGE;                         issue(probe);
		// unknown charge and runtime, grace just run out
		probe = calm_request(ST_GRACE); probe.ups_flags = ON_BATT;
		probe.charge_percent  = CHARGE_MAX + 7'd1;
		probe.runtime_seconds = RUNTIME_UNKNOWN;
		probe.battery_since   = probe.now_seconds - RST_GRACE;          issue(probe);
		probe.battery_since   = '0;                                     issue(probe);
		probe.battery_since   = probe.now_seconds + 32'd5;              issue(probe);
		probe = calm_request(ST_SHUTDOWN); probe.record_flags = REC_SENT; issue(probe);
		probe = calm_request(ST_SHUTDOWN);                              issue(probe);
		probe = calm_request(ST_WAIT_OFF); probe.host_flags = HOST_OFF; issue(probe);
		probe = calm_request(ST_WAIT_OFF);                              issue(probe);
		probe = calm_request(ST_CUTTING);  probe.outlet_state = OUTLET_OFF; issue(probe);
		probe = calm_request(ST_CUTTING);  probe.outlet_state = OUTLET_BAD; issue(probe);
		probe = calm_request(ST_WAIT_MAINS);                            issue(probe);
		probe = calm_request(ST_WAIT_MAINS); probe.ups_flags = ON_BATT; issue(probe);
		probe = calm_request(ST_STABILISING); probe.ups_flags = ON_BATT; issue(probe);
		probe = calm_request(ST_STABILISING);
		probe.mains_since = probe.now_seconds - RST_MAINS_STABLE;       issue(probe);
		probe.record_flags     = REC_CUT;
		probe.outlet_off_since = probe.now_seconds - RST_MIN_OFF;       issue(probe);
		probe.outlet_off_since = probe.now_seconds - RST_MIN_OFF + 32'd1; issue(probe);
		probe = calm_request(ST_RESTORING); probe.outlet_state = OUTLET_ON; issue(probe);
		probe = calm_request(ST_RESTORING); probe.outlet_state = OUTLET_UNKNOWN; issue(probe);
		probe = calm_request(ST_RECOVERY); probe.host_flags = HOST_UP;  issue(probe);
		probe = calm_request(ST_RECOVERY);                              issue(probe);
		probe = calm_request(ST_ERROR);                                 issue(probe);
		probe = calm_request(ST_SPARE_LO);                              issue(probe);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: program_regs(1'b1, RST_USE_LOW_BATT, RST_CRIT_CHARGE, RST_CRIT_RUNTIME,
				RST_GRACE, RST_MAINS_STABLE, RST_MIN_OFF);
			1: program_regs(1'b1, 1'b0, '0, '0, '0, '0, '0);
			2: program_regs(1'b1, 1'b1, CHARGE_MAX, RUNTIME_UNKNOWN - 16'd1, '1, '1, '1);
			4: program_regs(1'b0, 1'b0, 7'($urandom_range(100)), 16'($urandom_range(65534)),
				$urandom, $urandom, $urandom);
			default: program_regs(1'b1, 1'($urandom_range(1)), 7'($urandom_range(100)),
				16'($urandom_range(65534)), $urandom_range(5000), $urandom_range(5000),
				$urandom_range(5000));
			endcase
			case (ph % 3)
			0:       sender_idle = 0;
			1:       sender_idle = 61;
			default: sender_idle = 28;
			endcase
			repeat ((ph == 4) ? 150 : 340) issue(random_request());
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("ups_shutdown_sequencer_tb OK");
		else
			$display("ups_shutdown_sequencer_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("ups_shutdown_sequencer_tb NOT OK");
		$finish;
	end

endmodule
